@@ sv/sll_pkg.sv @@
// Shared types and constants of the shell line lexer.
package sll_pkg;

	// Lexer mode, one-hot
	typedef enum logic [4:0] {
		M_BETWEEN = 5'b00001,
		M_UNQ     = 5'b00010,
		M_DQ      = 5'b00100,
		M_SQ      = 5'b01000,
		M_COMMENT = 5'b10000
	} lex_mode_t;

	// Held lookahead byte, one-hot
	typedef enum logic [3:0] {
		H_NONE = 4'b0001,
		H_GT   = 4'b0010,
		H_LT   = 4'b0100,
		H_TWO  = 4'b1000
	} held_t;

	// Result kinds
	typedef enum logic [3:0] {
		K_BYTE    = 4'd0,
		K_END     = 4'd1,
		K_PIPE    = 4'd2,
		K_BG      = 4'd3,
		K_OUT     = 4'd4,
		K_APPEND  = 4'd5,
		K_IN      = 4'd6,
		K_HEREDOC = 4'd7,
		K_ERR     = 4'd8,
		K_LINE    = 4'd9
	} kind_t;

	localparam int MAX_RES = 3;
	localparam int RES_CW  = 2;

	// Queue between front and back; depth must be a power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  value;
	} res_t;

	// All results caused by one input item
	typedef struct packed {
		logic [RES_CW-1:0]  cnt;
		res_t [MAX_RES-1:0] res;
	} grp_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ sv/sll_front.sv @@
// Front end: accepts bytes, runs the lexer and builds one result group per item.
module sll_front import sll_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] char_byte,
	input  logic       line_end,
	input  q_stat_t    q_stat,
	output logic       full,
	output logic       q_wr_en,
	output grp_t       q_wr_data
);

	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_TWO    = 8'h32;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef struct packed {
		lex_mode_t mode;
		logic      esc;
		held_t     held;
		logic      cmt_single;
		logic      cmt_double;
		logic      cmt_esc;
	} lex_state_t;

	typedef struct packed {
		lex_state_t st;
		grp_t       g;
	} step_t;

	localparam lex_state_t LEX_RESET = '{
		mode: M_BETWEEN, esc: 1'b0, held: H_NONE,
		cmt_single: 1'b0, cmt_double: 1'b0, cmt_esc: 1'b0
	};

	function automatic logic is_ws(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_NL ||
			c == CH_VT || c == CH_FF || c == CH_CR;
	endfunction

	// Append one result; extra results beyond the group size are dropped
	function automatic step_t put(step_t s, kind_t k, logic [7:0] v);
		step_t r;
		r = s;
		if (s.g.cnt != RES_CW'(MAX_RES)) begin
			r.g.res[s.g.cnt].kind  = k;
			r.g.res[s.g.cnt].value = v;
			r.g.cnt = s.g.cnt + RES_CW'(1);
		end
		return r;
	endfunction

	// Byte inside an unquoted token
	function automatic step_t unq_byte(step_t s, logic [7:0] c);
		step_t r;
		r = s;
		if (s.st.esc) begin
			r.st.esc = 1'b0;
			r = put(r, K_BYTE, c);
		end else if (is_ws(c)) begin
			r = put(r, K_END, 8'h00);
			r.st.mode = M_BETWEEN;
		end else if (c == CH_PIPE || c == CH_AMP) begin
			r = put(r, K_END, 8'h00);
			r.st.mode = M_BETWEEN;
			r = put(r, (c == CH_PIPE) ? K_PIPE : K_BG, 8'h00);
		end else if (c == CH_GT || c == CH_LT) begin
			r = put(r, K_END, 8'h00);
			r.st.mode = M_BETWEEN;
			r.st.held = (c == CH_GT) ? H_GT : H_LT;
		end else if (c == CH_BSLASH) begin
			r.st.esc = 1'b1;
		end else begin
			r = put(r, K_BYTE, c);
		end
		return r;
	endfunction

	// Byte between tokens
	function automatic step_t between_byte(step_t s, logic [7:0] c);
		step_t r;
		r = s;
		if (!is_ws(c)) begin
			case (c)
				CH_PIPE:   r = put(r, K_PIPE, 8'h00);
				CH_AMP:    r = put(r, K_BG, 8'h00);
				CH_GT:     r.st.held = H_GT;
				CH_LT:     r.st.held = H_LT;
				CH_TWO:    r.st.held = H_TWO;
				CH_DQUOTE: r.st.mode = M_DQ;
				CH_SQUOTE: r.st.mode = M_SQ;
				CH_BSLASH: begin
					r.st.mode = M_UNQ;
					r.st.esc  = 1'b1;
				end
				default: begin
					r.st.mode = M_UNQ;
					r = put(r, K_BYTE, c);
				end
			endcase
		end
		return r;
	endfunction

	// Ordinary byte: resolve a held byte first, then lex by mode
	function automatic step_t lex_byte(step_t s, logic [7:0] c);
		step_t r;
		r = s;
		if (s.st.held != H_NONE) begin
			r.st.held = H_NONE;
			unique case (s.st.held)
				H_GT: begin
					if (c == CH_GT) r = put(r, K_APPEND, 8'h00);
					else begin
						r = put(r, K_OUT, 8'h00);
						r = between_byte(r, c);
					end
				end
				H_LT: begin
					if (c == CH_LT) r = put(r, K_HEREDOC, 8'h00);
					else begin
						r = put(r, K_IN, 8'h00);
						r = between_byte(r, c);
					end
				end
				default: begin
					if (c == CH_GT) r = put(r, K_ERR, 8'h00);
					else begin
						r = put(r, K_BYTE, CH_TWO);
						r.st.mode = M_UNQ;
						r = unq_byte(r, c);
					end
				end
			endcase
		end else begin
			unique case (s.st.mode)
				M_UNQ: r = unq_byte(r, c);
				M_DQ: begin
					if (s.st.esc) begin
						r.st.esc = 1'b0;
						r = put(r, K_BYTE, (c == CH_N) ? CH_NL : ((c == CH_T) ? CH_TAB : c));
					end else if (c == CH_BSLASH) begin
						r.st.esc = 1'b1;
					end else if (c == CH_DQUOTE) begin
						r = put(r, K_END, 8'h00);
						r.st.mode = M_BETWEEN;
					end else begin
						r = put(r, K_BYTE, c);
					end
				end
				M_SQ: begin
					if (c == CH_SQUOTE) begin
						r = put(r, K_END, 8'h00);
						r.st.mode = M_BETWEEN;
					end else begin
						r = put(r, K_BYTE, c);
					end
				end
				default: begin
					r.st.mode = M_BETWEEN;
					r = between_byte(r, c);
				end
			endcase
		end
		return r;
	endfunction

	// Close held bytes and any open token
	function automatic step_t flush(step_t s);
		step_t r;
		r = s;
		if (s.st.held == H_GT) r = put(r, K_OUT, 8'h00);
		else if (s.st.held == H_LT) r = put(r, K_IN, 8'h00);
		else if (s.st.held == H_TWO) begin
			r = put(r, K_BYTE, CH_TWO);
			r = put(r, K_END, 8'h00);
		end
		r.st.held = H_NONE;
		if (s.st.mode == M_UNQ || s.st.mode == M_DQ || s.st.mode == M_SQ) begin
			if (s.st.esc) r = put(r, K_BYTE, CH_BSLASH);
			r = put(r, K_END, 8'h00);
		end
		r.st.mode = M_BETWEEN;
		r.st.esc  = 1'b0;
		return r;
	endfunction

	lex_state_t st_q;
	step_t      nxt;
	logic       accept;

	// One lexer step per item
	always_comb begin
		nxt.st = st_q;
		nxt.g  = '0;
		if (line_end) begin
			nxt = flush(nxt);
			nxt = put(nxt, K_LINE, 8'h00);
			nxt.st = LEX_RESET;
		end else if (st_q.mode == M_COMMENT) begin
			nxt.st = st_q;
		end else if (st_q.cmt_esc) begin
			nxt.st.cmt_esc = 1'b0;
			nxt = lex_byte(nxt, char_byte);
		end else if (char_byte == CH_SQUOTE && !st_q.cmt_double) begin
			nxt.st.cmt_single = ~st_q.cmt_single;
			nxt = lex_byte(nxt, char_byte);
		end else if (char_byte == CH_DQUOTE && !st_q.cmt_single) begin
			nxt.st.cmt_double = ~st_q.cmt_double;
			nxt = lex_byte(nxt, char_byte);
		end else if (char_byte == CH_BSLASH && !st_q.cmt_single) begin
			nxt.st.cmt_esc = 1'b1;
			nxt = lex_byte(nxt, char_byte);
		end else if (char_byte == CH_HASH && !st_q.cmt_single && !st_q.cmt_double) begin
			nxt = flush(nxt);
			nxt.st.mode = M_COMMENT;
		end else begin
			nxt = lex_byte(nxt, char_byte);
		end
	end

	assign full      = q_stat.full;
	assign accept    = push && !q_stat.full;
	assign q_wr_en   = accept && (nxt.g.cnt != '0);
	assign q_wr_data = nxt.g;

	// Lexer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= LEX_RESET;
		end else if (accept) begin
			st_q <= nxt.st;
		end
	end

endmodule

@@ sv/sll_queue.sv @@
// Short queue of result groups between front and back.
module sll_queue import sll_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  grp_t    wr_data,
	input  logic    rd_en,
	output grp_t    rd_data,
	output q_stat_t stat
);

	grp_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_wr;
	logic                do_rd;

	assign stat.full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_wr      = wr_en && !stat.full;
	assign do_rd      = rd_en && !stat.empty;
	assign rd_data    = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (do_rd) rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			if (do_wr && !do_rd) count_q <= count_q + (QUEUE_AW+1)'(1);
			else if (do_rd && !do_wr) count_q <= count_q - (QUEUE_AW+1)'(1);
		end
	end

endmodule

@@ sv/sll_back.sv @@
// Back end: unpacks result groups and delivers one result item per pop.
module sll_back import sll_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  q_stat_t    q_stat,
	input  grp_t       q_rd_data,
	output logic       q_rd_en,
	input  logic       pop,
	output logic       empty,
	output logic [3:0] kind,
	output logic [7:0] value,
	output logic       last
);

	grp_t              grp_q;
	logic              valid_q;
	logic [RES_CW-1:0] idx_q;
	logic              take;

	assign empty = !valid_q;
	assign last  = (idx_q == grp_q.cnt - RES_CW'(1));
	assign kind  = grp_q.res[idx_q].kind;
	assign value = grp_q.res[idx_q].value;

	// Load a new group when idle or when the final result of this one goes
	assign take    = !valid_q || (pop && last);
	assign q_rd_en = take && !q_stat.empty;

	always_ff @(posedge clk) begin
		if (q_rd_en) grp_q <= q_rd_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (take) begin
			valid_q <= !q_stat.empty;
			idx_q   <= '0;
		end else if (pop) begin
			idx_q <= idx_q + RES_CW'(1);
		end
	end

endmodule

@@ sv/shell_line_lexer_top.sv @@
// Top level of the shell line lexer: front, group queue and back.
//
// Input channel: one byte of the command line per item (char_byte), or a
// line end (line_end set). An item is taken at a clock edge with push high
// and full low. Each item yields zero to three result items.
// Result channel: kind, value and last sit on the ports while empty is low
// and are taken at an edge with pop high. last marks the final result that
// belongs to one input item; items that yield nothing produce no output.
// Path: the group of a taken item is written into the queue, then loaded
// into the back end's group register, and from there sits on the ports.
// Throughput: one item per cycle at the input while full is low; the back
// end delivers one result per cycle while pop is high and results wait.
// The front lexes each item combinationally; a four-group queue plus one
// group in the back end absorb output stalls, and full rises only when all
// of them are occupied.
// Reset: all lexer state returns to between tokens, nothing held, and the
// queue and back end are emptied.
module shell_line_lexer_top import sll_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_byte,
	input  logic       line_end,
	output logic       empty,
	input  logic       pop,
	output logic [3:0] kind,
	output logic [7:0] value,
	output logic       last
);

	q_stat_t q_stat;
	logic    q_wr_en;
	grp_t    q_wr_data;
	logic    q_rd_en;
	grp_t    q_rd_data;

	sll_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.char_byte (char_byte),
		.line_end  (line_end),
		.q_stat    (q_stat),
		.full      (full),
		.q_wr_en   (q_wr_en),
		.q_wr_data (q_wr_data)
	);

	sll_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr_en),
		.wr_data (q_wr_data),
		.rd_en   (q_rd_en),
		.rd_data (q_rd_data),
		.stat    (q_stat)
	);

	sll_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_rd_data (q_rd_data),
		.q_rd_en   (q_rd_en),
		.pop       (pop),
		.empty     (empty),
		.kind      (kind),
		.value     (value),
		.last      (last)
	);

endmodule

@@ tb/sv/testbench.sv @@
// Testbench for shell_line_lexer_top: directed and random command lines checked against a predictor.
`timescale 1ns / 1ps

module testbench;
	import sll_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_TARGET = 255;
	localparam int TOTAL_TARGET = 295;

	// Bytes the lexer treats specially, plus the dollar sign used as stimulus
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_TWO    = 8'h32;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;

	typedef struct {
		kind_t      kind;
		logic [7:0] value;
		logic       last;
	} lex_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [7:0] char_byte = 8'h00;
	logic       line_end = 1'b0;
	logic       pop = 1'b0;
	logic       full;
	logic       empty;
	logic [3:0] kind;
	logic [7:0] value;
	logic       last;

	// Predictor state
	lex_mode_t lx_mode;
	logic      lx_esc;
	held_t     lx_held;
	logic      scan_sq, scan_dq, scan_esc;

	lex_result_t tokens_due[$];
	lex_result_t step_res[$];
	lex_result_t due;
	int          live_items = 0;
	int          errors = 0;
	int          cycles = 0;
	int          sink_stall = 0;
	bit          src_idle_on = 1'b1;
	bit          sink_idle_on = 1'b1;
	string       word_chars = "abcdefxyzABZ0129_-./=:";

	shell_line_lexer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.char_byte (char_byte),
		.line_end  (line_end),
		.empty     (empty),
		.pop       (pop),
		.kind      (kind),
		.value     (value),
		.last      (last)
	);

	always #5 clk = ~clk;

	// Run-length guard
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ---------------- predictor ----------------

	function automatic void clear_lexer_state();
		lx_mode = M_BETWEEN;
		lx_esc = 1'b0;
		lx_held = H_NONE;
		scan_sq = 1'b0;
		scan_dq = 1'b0;
		scan_esc = 1'b0;
	endfunction

	function automatic void emit(kind_t k, logic [7:0] v);
		lex_result_t r;
		if (step_res.size() < MAX_RES) begin
			r.kind = k;
			r.value = v;
			r.last = 1'b0;
			step_res.push_back(r);
		end
	endfunction

	function automatic bit is_space(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_VT
			|| c == CH_FF || c == CH_CR;
	endfunction

	// Byte inside an unquoted word
	function automatic void unquoted_byte(logic [7:0] c);
		if (lx_esc) begin
			lx_esc = 1'b0;
			emit(K_BYTE, c);
		end else if (is_space(c)) begin
			emit(K_END, 8'h00);
			lx_mode = M_BETWEEN;
		end else if (c == CH_PIPE || c == CH_AMP) begin
			emit(K_END, 8'h00);
			lx_mode = M_BETWEEN;
			if (c == CH_PIPE)
				emit(K_PIPE, 8'h00);
			else
				emit(K_BG, 8'h00);
		end else if (c == CH_GT || c == CH_LT) begin
			emit(K_END, 8'h00);
			lx_mode = M_BETWEEN;
			if (c == CH_GT)
				lx_held = H_GT;
			else
				lx_held = H_LT;
		end else if (c == CH_BSLASH) begin
			lx_esc = 1'b1;
		end else begin
			emit(K_BYTE, c);
		end
	endfunction

	// Byte at a token start
	function automatic void token_start_byte(logic [7:0] c);
		if (!is_space(c)) begin
			case (c)
				CH_PIPE:   emit(K_PIPE, 8'h00);
				CH_AMP:    emit(K_BG, 8'h00);
				CH_GT:     lx_held = H_GT;
				CH_LT:     lx_held = H_LT;
				CH_TWO:    lx_held = H_TWO;
				CH_DQUOTE: lx_mode = M_DQ;
				CH_SQUOTE: lx_mode = M_SQ;
				CH_BSLASH: begin
					lx_mode = M_UNQ;
					lx_esc = 1'b1;
				end
				default: begin
					lx_mode = M_UNQ;
					emit(K_BYTE, c);
				end
			endcase
		end
	endfunction

	function automatic void lex_char(logic [7:0] c);
		held_t h;
		h = lx_held;
		if (h != H_NONE) begin
			// the lookahead byte decides what the held one was
			lx_held = H_NONE;
			case (h)
				H_GT: begin
					if (c == CH_GT) begin
						emit(K_APPEND, 8'h00);
					end else begin
						emit(K_OUT, 8'h00);
						token_start_byte(c);
					end
				end
				H_LT: begin
					if (c == CH_LT) begin
						emit(K_HEREDOC, 8'h00);
					end else begin
						emit(K_IN, 8'h00);
						token_start_byte(c);
					end
				end
				default: begin
					if (c == CH_GT) begin
						emit(K_ERR, 8'h00);
					end else begin
						emit(K_BYTE, CH_TWO);
						lx_mode = M_UNQ;
						unquoted_byte(c);
					end
				end
			endcase
		end else begin
			case (lx_mode)
				M_UNQ: unquoted_byte(c);
				M_DQ: begin
					if (lx_esc) begin
						lx_esc = 1'b0;
						if (c == CH_N)
							emit(K_BYTE, CH_NL);
						else if (c == CH_T)
							emit(K_BYTE, CH_TAB);
						else
							emit(K_BYTE, c);
					end else if (c == CH_BSLASH) begin
						lx_esc = 1'b1;
					end else if (c == CH_DQUOTE) begin
						emit(K_END, 8'h00);
						lx_mode = M_BETWEEN;
					end else begin
						emit(K_BYTE, c);
					end
				end
				M_SQ: begin
					if (c == CH_SQUOTE) begin
						emit(K_END, 8'h00);
						lx_mode = M_BETWEEN;
					end else begin
						emit(K_BYTE, c);
					end
				end
				default: begin
					lx_mode = M_BETWEEN;
					token_start_byte(c);
				end
			endcase
		end
	endfunction

	// Close whatever is held or open
	function automatic void flush_line();
		case (lx_held)
			H_GT: emit(K_OUT, 8'h00);
			H_LT: emit(K_IN, 8'h00);
			H_TWO: begin
				emit(K_BYTE, CH_TWO);
				emit(K_END, 8'h00);
			end
			default: ;
		endcase
		lx_held = H_NONE;
		if (lx_mode == M_UNQ || lx_mode == M_DQ || lx_mode == M_SQ) begin
			if (lx_esc)
				emit(K_BYTE, CH_BSLASH);
			emit(K_END, 8'h00);
		end
		lx_mode = M_BETWEEN;
		lx_esc = 1'b0;
	endfunction

	// Expected results of one accepted item
	function automatic void predict_item(logic [7:0] c, logic le);
		bit opens;
		opens = 1'b0;
		step_res.delete();
		live_items++;
		if (le) begin
			flush_line();
			emit(K_LINE, 8'h00);
			clear_lexer_state();
		end else if (lx_mode != M_COMMENT) begin
			// comment scan keeps its own quote tracking
			if (scan_esc)
				scan_esc = 1'b0;
			else if (c == CH_SQUOTE && !scan_dq)
				scan_sq = ~scan_sq;
			else if (c == CH_DQUOTE && !scan_sq)
				scan_dq = ~scan_dq;
			else if (c == CH_BSLASH && !scan_sq)
				scan_esc = 1'b1;
			else if (c == CH_HASH && !scan_sq && !scan_dq)
				opens = 1'b1;
			if (opens) begin
				flush_line();
				lx_mode = M_COMMENT;
			end else begin
				lex_char(c);
			end
		end
		foreach (step_res[i]) begin
			step_res[i].last = (i == step_res.size() - 1);
			tokens_due.push_back(step_res[i]);
		end
	endfunction

	// ---------------- result side ----------------

	// Consumer with random stall bursts
	always @(negedge clk) begin
		if (sink_stall > 0) begin
			pop <= 1'b0;
			sink_stall <= sink_stall - 1;
		end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
			pop <= 1'b0;
			sink_stall <= $urandom_range(0, 13);
		end else begin
			pop <= 1'b1;
		end
	end

	// Compare each taken result with the oldest expected one
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (tokens_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual kind %0d value %0h last %0b",
					$time, kind, value, last);
			end else begin
				due = tokens_due.pop_front();
				if (kind !== due.kind) begin
					errors++;
					$display("%0t: kind expected %0d, actual %0d", $time, due.kind, kind);
				end
				if (value !== due.value) begin
					errors++;
					$display("%0t: value expected %0h, actual %0h", $time, due.value, value);
				end
				if (last !== due.last) begin
					errors++;
					$display("%0t: last expected %0b, actual %0b", $time, due.last, last);
				end
			end
		end
	end

	// ---------------- input side ----------------

	task automatic send_item(input logic [7:0] c, input logic le);
		int gap;
		if (src_idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 14);
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		char_byte <= c;
		line_end <= le;
		do @(posedge clk); while (full);
		predict_item(c, le);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	task automatic end_line();
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		push <= 1'b0;
		while (tokens_due.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] word_byte();
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom_range(0, 255));
		return word_chars[$urandom_range(0, word_chars.len() - 1)];
	endfunction

	function automatic logic [7:0] space_byte();
		case ($urandom_range(0, 9))
			0: return CH_TAB;
			1: return CH_NL;
			2: return CH_VT;
			3: return CH_FF;
			4: return CH_CR;
			default: return CH_SPACE;
		endcase
	endfunction

	// Line with random content, at times an unclosed quote or a trailing backslash, then a line end
	task automatic send_random_line();
		logic [7:0] text[$];
		int ntok, len;
		ntok = $urandom_range(0, 6);
		for (int t = 0; t < ntok; t++) begin
			repeat ($urandom_range(t > 0 ? 0 : 0, 2)) text.push_back(space_byte());
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					// plain word, sometimes with an escaped byte
					len = $urandom_range(1, 5);
					for (int k = 0; k < len; k++) begin
						if ($urandom_range(0, 5) == 0) begin
							text.push_back(CH_BSLASH);
							text.push_back(8'($urandom_range(0, 255)));
						end else begin
							text.push_back(word_byte());
						end
					end
				end
				4: begin
					text.push_back(CH_DQUOTE);
					len = $urandom_range(0, 4);
					for (int k = 0; k < len; k++) begin
						if ($urandom_range(0, 3) == 0) begin
							text.push_back(CH_BSLASH);
							case ($urandom_range(0, 5))
								0: text.push_back(CH_N);
								1: text.push_back(CH_T);
								2: text.push_back(CH_BSLASH);
								3: text.push_back(CH_DQUOTE);
								4: text.push_back(CH_DOLLAR);
								default: text.push_back(8'($urandom_range(0, 255)));
							endcase
						end else begin
							text.push_back(word_byte());
						end
					end
					if ($urandom_range(0, 7) != 0)
						text.push_back(CH_DQUOTE);
				end
				5: begin
					text.push_back(CH_SQUOTE);
					len = $urandom_range(0, 4);
					for (int k = 0; k < len; k++)
						text.push_back(word_byte());
					if ($urandom_range(0, 7) != 0)
						text.push_back(CH_SQUOTE);
				end
				6, 8: begin
					// operator, redirections often followed by a target word
					case ($urandom_range(0, 6))
						0: text.push_back(CH_PIPE);
						1: text.push_back(CH_AMP);
						2: text.push_back(CH_GT);
						3: begin
							text.push_back(CH_GT);
							text.push_back(CH_GT);
						end
						4: text.push_back(CH_LT);
						5: begin
							text.push_back(CH_LT);
							text.push_back(CH_LT);
						end
						default: begin
							text.push_back(CH_TWO);
							text.push_back(CH_GT);
						end
					endcase
					if ($urandom_range(0, 1) == 0)
						text.push_back(word_byte());
				end
				7: begin
					text.push_back(CH_TWO);
					if ($urandom_range(0, 1) == 0)
						text.push_back(word_byte());
				end
				default: begin
					// trailing comment
					text.push_back(CH_HASH);
					repeat ($urandom_range(0, 3)) text.push_back(word_byte());
					break;
				end
			endcase
		end
		if ($urandom_range(0, 9) == 0)
			text.push_back(CH_BSLASH);
		foreach (text[i])
			send_item(text[i], 1'b0);
		end_line();
	endtask

	// Raw bytes with an occasional line end
	task automatic send_noise();
		repeat ($urandom_range(1, 12))
			send_item(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
	endtask

	// ---------------- tests ----------------

	// Every operator, quoting, escapes, comment, flush of held bytes
	task automatic test_directed_operators();
		send_text("2>a|\"\\n\"&''#x");
		end_line();
		send_text(">b<<c\\");
		end_line();
		send_text("<2");
		end_line();
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_text(">>");
		end_line();
	endtask

	// Sender holds off until the result queue has fully drained
	task automatic test_pause_until_drained();
		send_text("cat<in>>out 2x");
		wait_drained();
		end_line();
	endtask

	task automatic test_random_lines();
		while (live_items < RANDOM_TARGET) begin
			if ($urandom_range(0, 4) == 0)
				send_noise();
			else
				send_random_line();
		end
	endtask

	// Both sides at full rate for the tail of the run
	task automatic test_full_rate();
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		while (live_items < TOTAL_TARGET)
			send_random_line();
	endtask

	initial begin
		clear_lexer_state();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		test_directed_operators();
		test_pause_until_drained();
		test_random_lines();
		test_full_rate();
		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ files.f @@
sv/sll_pkg.sv
sv/sll_front.sv
sv/sll_queue.sv
sv/sll_back.sv
sv/shell_line_lexer_top.sv
tb/sv/testbench.sv
